// ===== src/cda_pkg.sv =====
// Package with payload types, operation codes and calendar helper functions.
`timescale 1ns / 1ps
package cda_pkg;

   localparam int MaxYearDefault = 9999;

   localparam logic [3:0] FUNC_ADD_DAYS = 4'd0;
   localparam logic [3:0] FUNC_SUB_DAYS = 4'd1;
   localparam logic [3:0] FUNC_ADD_MON  = 4'd2;
   localparam logic [3:0] FUNC_SUB_MON  = 4'd3;
   localparam logic [3:0] FUNC_ADD_YRS  = 4'd4;
   localparam logic [3:0] FUNC_SUB_YRS  = 4'd5;
   localparam logic [3:0] FUNC_DOY      = 4'd6;
   localparam logic [3:0] FUNC_WEEK     = 4'd7;
   localparam logic [3:0] FUNC_DIFF     = 4'd8;
   localparam logic [3:0] FUNC_CHECK    = 4'd9;

   typedef struct packed {
      logic [3:0]  func;
      logic [4:0]  in_day;
      logic [3:0]  in_month;
      logic [13:0] in_year;
      logic [15:0] amount;
      logic [4:0]  other_day;
      logic [3:0]  other_month;
      logic [13:0] other_year;
   } req_type;

   typedef struct packed {
      logic [4:0]  out_day;
      logic [3:0]  out_month;
      logic [13:0] out_year;
      logic [21:0] number;
      logic        date_valid;
   } rsp_type;

   // Quotient by 100 through a reciprocal multiplication, exact below 2**17.
   function automatic logic [10:0] div100(input logic [16:0] y);
      logic [34:0] p;
      begin
         p = 35'(y) * 35'd167773;
         div100 = p[34:24];
      end
   endfunction

   function automatic logic is_leap(input logic [16:0] y);
      logic [10:0] q100;
      logic [6:0]  r100;
      begin
         q100 = div100(y);
         r100 = 7'(y - 17'(q100) * 17'd100);
         is_leap = (y[1:0] == 2'd0) && ((r100 != 7'd0) || (q100[1:0] == 2'd0));
      end
   endfunction

   function automatic logic [4:0] dim(input logic [3:0] m, input logic leap);
      begin
         unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: dim = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11: dim = 5'd30;
            4'd2: dim = leap ? 5'd29 : 5'd28;
            default: dim = 5'd0;
         endcase
      end
   endfunction

   // Days before the first of month m (1..12).
   function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
      logic [8:0] b;
      begin
         unique case (m)
            4'd1: b = 9'd0;    4'd2: b = 9'd31;   4'd3: b = 9'd59;
            4'd4: b = 9'd90;   4'd5: b = 9'd120;  4'd6: b = 9'd151;
            4'd7: b = 9'd181;  4'd8: b = 9'd212;  4'd9: b = 9'd243;
            4'd10: b = 9'd273; 4'd11: b = 9'd304; 4'd12: b = 9'd334;
            default: b = 9'd0;
         endcase
         days_before = (leap && m > 4'd2) ? b + 9'd1 : b;
      end
   endfunction

   // Days in all years before year p+1 (p = y - 1).
   function automatic logic [24:0] year_days(input logic [16:0] p);
      logic [10:0] q;
      begin
         q = div100(p);
         year_days = 25'(p) * 25'd365 + 25'(p >> 2) - 25'(q) + 25'(q >> 2);
      end
   endfunction

endpackage

// ===== src/calendar_date_arithmetic_top.sv =====
// Top level of the Gregorian date arithmetic pipeline.
// Throughput: one item per cycle while the response side is ready.
// Stages: decode, day count, two serial to year stages, and output, which holds the month search.
// Reset clears all stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module calendar_date_arithmetic_top #(
   parameter int MAX_YEAR = cda_pkg::MaxYearDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cda_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cda_pkg::rsp_type rsp_data
);
   import cda_pkg::*;

   localparam logic [16:0] MaxY = 17'(MAX_YEAR);

   logic adv;
   logic v1_ff, v2_ff, v3a_ff, v3_ff, v4_ff;
   assign adv = !v4_ff || rsp_ready;
   assign req_ready = adv;

   // Stage 1: validity, day of year, days before the year.
   req_type     r1_ff;
   logic        ok1_ff, ok1_in, ok2b1_ff, ok2b1_in;
   logic [8:0]  doy1_ff, doy1_in, doy2_ff, doy2_in;
   logic [24:0] yd1_ff, yd1_in, yd2_ff, yd2_in;
   logic        lp1, lp2;
   logic [4:0]  dim1;
   logic [4:0]  dim2;
   always_comb begin
      lp1 = is_leap(17'(req_data.in_year));
      lp2 = is_leap(17'(req_data.other_year));
      dim1 = dim(req_data.in_month, lp1);
      dim2 = dim(req_data.other_month, lp2);
      ok1_in = req_data.in_year != 14'd0 && 17'(req_data.in_year) <= MaxY
             && req_data.in_day != 5'd0 && req_data.in_day <= dim1;
      ok2b1_in = req_data.other_year != 14'd0 && 17'(req_data.other_year) <= MaxY
             && req_data.other_day != 5'd0 && req_data.other_day <= dim2;
      doy1_in = days_before(req_data.in_month, lp1) + 9'(req_data.in_day);
      doy2_in = days_before(req_data.other_month, lp2) + 9'(req_data.other_day);
      yd1_in = year_days(17'(req_data.in_year) - 17'd1);
      yd2_in = year_days(17'(req_data.other_year) - 17'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_valid;
      if (adv) begin
         r1_ff <= req_data; ok1_ff <= ok1_in; ok2b1_ff <= ok2b1_in;
         doy1_ff <= doy1_in; doy2_ff <= doy2_in;
         yd1_ff <= yd1_in; yd2_ff <= yd2_in;
      end
   end

   // Stage 2: serial numbers and the month and year steps.
   logic [24:0] lim;
   logic [24:0] sa, sb, t2_in, t2_ff;
   logic        hi2_in, lo2_in, hi2_ff, lo2_ff;
   logic [16:0] oy2_in, oy2_ff;
   logic [3:0]  om2_in, om2_ff;
   logic [21:0] num2_in, num2_ff;
   logic        ok2_in, ok2_ff;
   logic [3:0]  f2_ff;
   logic [4:0]  d2_ff;
   logic [18:0] idx;
   logic [39:0] yq_p;
   logic [16:0] yq;
   logic [8:0]  wk0;
   logic [17:0] wk_p;
   always_comb begin
      lim = year_days(MaxY - 17'd1) + 25'd365 + 25'(is_leap(MaxY));
      sa = yd1_ff + 25'(doy1_ff);
      sb = yd2_ff + 25'(doy2_ff);
      hi2_in = 1'b0; lo2_in = 1'b0; t2_in = sa;
      oy2_in = 17'(r1_ff.in_year); om2_in = r1_ff.in_month;
      num2_in = 22'd0; ok2_in = ok1_ff;
      idx = 19'(r1_ff.in_year) * 19'd12 + 19'(r1_ff.in_month) - 19'd1;
      yq_p = 40'd0;
      yq = 17'd0;
      wk0 = doy1_ff - 9'd1;
      wk_p = 18'(wk0) * 18'd586;
      unique case (r1_ff.func)
         FUNC_ADD_DAYS: begin
            t2_in = sa + 25'(r1_ff.amount);
            hi2_in = t2_in > lim;
         end
         FUNC_SUB_DAYS: begin
            lo2_in = 25'(r1_ff.amount) >= sa;
            t2_in = sa - 25'(r1_ff.amount);
         end
         FUNC_ADD_MON, FUNC_SUB_MON: begin
            if (r1_ff.func == FUNC_ADD_MON) idx = idx + 19'(r1_ff.amount);
            else if (19'(r1_ff.amount) + 19'd12 > idx) lo2_in = 1'b1;
            else idx = idx - 19'(r1_ff.amount);
            yq_p = 40'(idx) * 40'd699051;
            yq = 17'(yq_p[38:23]);
            oy2_in = yq;
            om2_in = 4'(idx - 19'(yq) * 19'd12 + 19'd1);
            if (!lo2_in && yq > MaxY) hi2_in = 1'b1;
         end
         FUNC_ADD_YRS: begin
            oy2_in = 17'(r1_ff.in_year) + 17'(r1_ff.amount);
            hi2_in = oy2_in > MaxY;
         end
         FUNC_SUB_YRS: begin
            lo2_in = r1_ff.amount >= 16'(r1_ff.in_year);
            oy2_in = 17'(r1_ff.in_year) - 17'(r1_ff.amount);
         end
         FUNC_DOY: num2_in = 22'(doy1_ff);
         FUNC_WEEK: num2_in = 22'(wk_p[17:12]) + 22'd1;
         FUNC_DIFF: begin
            num2_in = 22'(sa > sb ? sa - sb : sb - sa);
            if (!ok2b1_ff) begin ok2_in = 1'b0; num2_in = 22'd0; end
         end
         default: ;
      endcase
      if (!ok1_ff) begin
         num2_in = 22'd0; hi2_in = 1'b0; lo2_in = 1'b0;
         oy2_in = 17'(r1_ff.in_year); om2_in = r1_ff.in_month;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         t2_ff <= t2_in; hi2_ff <= hi2_in; lo2_ff <= lo2_in;
         oy2_ff <= oy2_in; om2_ff <= om2_in; num2_ff <= num2_in;
         ok2_ff <= ok2_in; f2_ff <= r1_ff.func; d2_ff <= r1_ff.in_day;
      end
   end

   // Stages 3 and 4: serial conversion, then clamping and output.
   logic [16:0] sy;
   logic [3:0]  sm;
   logic [4:0]  sd;
   cda_serial u_serial (
      .clock(clock), .adv(adv), .serial(t2_ff),
      .year(sy), .month(sm), .day(sd)
   );

   logic        hi3a_ff, lo3a_ff, ok3a_ff;
   logic [16:0] oy3a_ff;
   logic [3:0]  om3a_ff, f3a_ff;
   logic [21:0] num3a_ff;
   logic [4:0]  d3a_ff;
   always_ff @(posedge clock) begin
      if (reset) v3a_ff <= 1'b0;
      else if (adv) v3a_ff <= v2_ff;
      if (adv) begin
         hi3a_ff <= hi2_ff; lo3a_ff <= lo2_ff; ok3a_ff <= ok2_ff;
         oy3a_ff <= oy2_ff; om3a_ff <= om2_ff; f3a_ff <= f2_ff;
         num3a_ff <= num2_ff; d3a_ff <= d2_ff;
      end
   end

   logic        hi3_ff, lo3_ff, ok3_ff;
   logic [16:0] oy3_ff;
   logic [3:0]  om3_ff, f3_ff;
   logic [21:0] num3_ff;
   logic [4:0]  d3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v3a_ff;
      if (adv) begin
         hi3_ff <= hi3a_ff; lo3_ff <= lo3a_ff; ok3_ff <= ok3a_ff;
         oy3_ff <= oy3a_ff; om3_ff <= om3a_ff; f3_ff <= f3a_ff;
         num3_ff <= num3a_ff; d3_ff <= d3a_ff;
      end
   end

   rsp_type o_in, o_ff;
   logic [4:0]  cd, lim_d;
   logic [16:0] fy;
   logic [3:0]  fm;
   always_comb begin
      fy = oy3_ff; fm = om3_ff; cd = d3_ff;
      if (f3_ff == FUNC_ADD_DAYS || f3_ff == FUNC_SUB_DAYS) begin
         fy = sy; fm = sm; cd = sd;
      end
      lim_d = dim(fm, is_leap(fy));
      o_in.number = num3_ff;
      o_in.date_valid = ok3_ff;
      o_in.out_day = cd; o_in.out_month = fm; o_in.out_year = 14'(fy);
      if (ok3_ff && f3_ff <= FUNC_SUB_YRS) begin
         if (hi3_ff) begin
            o_in.out_day = 5'd31; o_in.out_month = 4'd12;
            o_in.out_year = 14'(MaxY); o_in.date_valid = 1'b0;
         end else if (lo3_ff) begin
            o_in.out_day = 5'd1; o_in.out_month = 4'd1;
            o_in.out_year = 14'd1; o_in.date_valid = 1'b0;
         end else if (cd > lim_d) begin
            o_in.out_day = lim_d;
         end
      end
      if (!ok3_ff && f3_ff <= FUNC_SUB_YRS) begin
         o_in.out_day = d3_ff; o_in.out_month = om3_ff; o_in.out_year = 14'(oy3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
      if (adv) o_ff <= o_in;
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = o_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response item changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipeline stalled with empty output");
   a_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.date_valid && rsp_data.number != 22'd0 |-> 1'b0)
      else $error("number set on an invalid item");
endmodule

// ===== src/cda_serial.sv =====
// Serial day number to year, month and day conversion across two register stages.
`timescale 1ns / 1ps
module cda_serial (
   input  logic        clock,
   input  logic        adv,
   input  logic [24:0] serial,
   output logic [16:0] year,
   output logic [3:0]  month,
   output logic [4:0]  day
);
   import cda_pkg::*;

   logic [7:0]  q400_ff, q400_in;
   logic [1:0]  q100_ff, q100_in;
   logic [15:0] r100_ff, r100_in;
   logic [16:0] yr_ff, yr_in;
   logic [8:0]  doy_ff, doy_in;
   logic [24:0] n;
   logic [50:0] p400;
   logic [17:0] r400;
   logic [30:0] p4;
   logic [4:0]  q4;
   logic [10:0] r4;
   logic [1:0]  q1;
   logic        lp;
   logic [3:0]  mo;

   always_comb begin
      n       = serial - 25'd1;
      p400    = 51'(n) * 51'd60207212;
      q400_in = p400[50:43];
      r400    = 18'(n - 25'(q400_in) * 25'd146097);
      q100_in = 2'(r400 >= 18'd36524) + 2'(r400 >= 18'd73048) + 2'(r400 >= 18'd109572);
      r100_in = 16'(r400 - 18'(q100_in) * 18'd36524);
   end

   always_comb begin
      p4     = 31'(r100_ff) * 31'd45934;
      q4     = p4[30:26];
      r4     = 11'(r100_ff - 16'(q4) * 16'd1461);
      q1     = 2'(r4 >= 11'd365) + 2'(r4 >= 11'd730) + 2'(r4 >= 11'd1095);
      doy_in = 9'(r4 - 11'(q1) * 11'd365);
      yr_in  = 17'(q400_ff) * 17'd400 + 17'(q100_ff) * 17'd100 + 17'(q4) * 17'd4
             + 17'(q1) + 17'd1;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q400_ff <= q400_in;
         q100_ff <= q100_in;
         r100_ff <= r100_in;
         yr_ff   <= yr_in;
         doy_ff  <= doy_in;
      end
   end

   always_comb begin
      lp = is_leap(yr_ff);
      mo = 4'd12;
      for (int k = 12; k >= 2; k--) begin
         if (doy_ff < days_before(4'(k), lp)) mo = 4'(k - 1);
      end
      year  = yr_ff;
      month = mo;
      day   = 5'(doy_ff - days_before(mo, lp) + 9'd1);
   end
endmodule
